FILE: rtl/core/horizontal_binomial_blur_assert.svh
// assertion macros for the horizontal binomial blur checker
`ifndef HORIZONTAL_BINOMIAL_BLUR_ASSERT_SVH
`define HORIZONTAL_BINOMIAL_BLUR_ASSERT_SVH

// same-cycle implication
`define HBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hbb assertion failed");

// next-cycle implication
`define HBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hbb assertion failed");

`endif

FILE: rtl/core/hbb_pkg.sv
// shared types and constants for the horizontal binomial blur
package hbb_pkg;

	localparam int CHAN_W     = 8;
	localparam int ROW_W      = 13;
	localparam int CMP_W      = 17;
	localparam int TAPS       = 5;
	localparam int SLOTS      = 3;
	localparam int SUM_W      = 12;
	localparam int MAX_WIDTH  = 4096;
	localparam logic [ROW_W-1:0] ROW_WIDTH_RST = ROW_W'(640);

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	// results produced by one input word, one slot per lane
	typedef struct packed {
		logic [SLOTS-1:0]         mask;
		pixel_t [SLOTS-1:0]       px;
	} run_t;

endpackage

FILE: rtl/core/hbb_in_if.sv
// input pixel channel
interface hbb_in_if;
	logic                      valid;
	logic                      ready;
	logic [hbb_pkg::CHAN_W-1:0] red_in;
	logic [hbb_pkg::CHAN_W-1:0] green_in;
	logic [hbb_pkg::CHAN_W-1:0] blue_in;

	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

FILE: rtl/core/hbb_out_if.sv
// output pixel channel
interface hbb_out_if;
	logic                      valid;
	logic                      ready;
	logic [hbb_pkg::CHAN_W-1:0] red_out;
	logic [hbb_pkg::CHAN_W-1:0] green_out;
	logic [hbb_pkg::CHAN_W-1:0] blue_out;
	logic                      row_end;
	logic                      last_of_run;

	modport source (output valid, red_out, green_out, blue_out, row_end, last_of_run,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, row_end, last_of_run,
		output ready);
endinterface

FILE: rtl/core/horizontal_binomial_blur.sv
// horizontal 5-tap binomial blur, top level
// a result word passes through the merging stage's pending and output registers
// one pixel per cycle while ready is high; a row-end pixel yields up to three words,
// one per cycle when pix_out is ready; the input waits while merging drains them
// arst_n clears row history, column count and pending results; row width resets to 640
module horizontal_binomial_blur #(
	parameter int MAX_WIDTH = hbb_pkg::MAX_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [hbb_pkg::ROW_W-1:0] cfg_wr_data,
	hbb_in_if.sink                    pix_in,
	hbb_out_if.source                 pix_out
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [hbb_pkg::CMP_W-1:0] MAXW = hbb_pkg::CMP_W'(MAX_WIDTH);

	logic [hbb_pkg::ROW_W-1:0]   row_width_q;
	logic [CW-1:0]               col_q;
	hbb_pkg::pixel_t [3:0]       hist_q;
	hbb_pkg::pixel_t [3:0]       hist;
	hbb_pkg::pixel_t             cur;
	logic [hbb_pkg::CMP_W-1:0]   eff_w;
	logic [hbb_pkg::CMP_W-1:0]   col_ext;
	logic                        last;
	logic                        accept;
	logic                        free;
	hbb_pkg::run_t               run;

	assign cur.red   = pix_in.red_in;
	assign cur.green = pix_in.green_in;
	assign cur.blue  = pix_in.blue_in;
	assign accept    = pix_in.valid && free;
	assign pix_in.ready = free;

	always_comb begin
		eff_w = hbb_pkg::CMP_W'(row_width_q);
		if (eff_w == '0) begin
			eff_w = hbb_pkg::CMP_W'(1);
		end
		if (eff_w > MAXW) begin
			eff_w = MAXW;
		end
	end

	assign col_ext = hbb_pkg::CMP_W'(col_q);
	assign last    = (col_ext >= eff_w - hbb_pkg::CMP_W'(1));

	// left edge replication on the first column
	always_comb begin
		if (col_q == '0) begin
			hist = {4{cur}};
		end else begin
			hist = hist_q;
		end
	end

	hbb_lane u_lane0 (
		.taps ({cur, hist[0], hist[1], hist[2], hist[3]}),
		.px   (run.px[0])
	);

	hbb_lane u_lane1 (
		.taps ({cur, cur, hist[0], hist[1], hist[2]}),
		.px   (run.px[1])
	);

	hbb_lane u_lane2 (
		.taps ({cur, cur, cur, hist[0], hist[1]}),
		.px   (run.px[2])
	);

	assign run.mask[0] = (col_ext >= hbb_pkg::CMP_W'(2));
	assign run.mask[1] = last && (col_q != '0);
	assign run.mask[2] = last;

	hbb_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.run     (run),
		.free    (free),
		.pix_out (pix_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= hbb_pkg::ROW_WIDTH_RST;
		end else if (cfg_wr_en) begin
			row_width_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			hist_q <= '0;
		end else if (accept) begin
			hist_q <= {hist[2], hist[1], hist[0], cur};
			if (last) begin
				col_q <= '0;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/hbb_lane.sv
// one filter lane: 1-4-6-4-1 kernel over five pixels, all three channels
module hbb_lane (
	input  hbb_pkg::pixel_t [hbb_pkg::TAPS-1:0] taps,
	output hbb_pkg::pixel_t                     px
);

	function automatic logic [hbb_pkg::CHAN_W-1:0] blur5(
		input logic [hbb_pkg::CHAN_W-1:0] a,
		input logic [hbb_pkg::CHAN_W-1:0] b,
		input logic [hbb_pkg::CHAN_W-1:0] c,
		input logic [hbb_pkg::CHAN_W-1:0] d,
		input logic [hbb_pkg::CHAN_W-1:0] e
	);
		logic [hbb_pkg::SUM_W-1:0] sum;
		sum = hbb_pkg::SUM_W'(a) + hbb_pkg::SUM_W'(e)
			+ (hbb_pkg::SUM_W'(b) << 2) + (hbb_pkg::SUM_W'(d) << 2)
			+ (hbb_pkg::SUM_W'(c) << 2) + (hbb_pkg::SUM_W'(c) << 1);
		return sum[hbb_pkg::SUM_W-1:4];
	endfunction

	assign px.red   = blur5(taps[0].red, taps[1].red, taps[2].red, taps[3].red,
		taps[4].red);
	assign px.green = blur5(taps[0].green, taps[1].green, taps[2].green, taps[3].green,
		taps[4].green);
	assign px.blue  = blur5(taps[0].blue, taps[1].blue, taps[2].blue, taps[3].blue,
		taps[4].blue);

endmodule

FILE: rtl/core/hbb_merge.sv
// merging stage: holds the lane results of one word and sends them out in order
module hbb_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hbb_pkg::run_t     run,
	output logic              free,
	hbb_out_if.source         pix_out
);

	logic [hbb_pkg::SLOTS-1:0]  pend_s1;
	hbb_pkg::pixel_t [hbb_pkg::SLOTS-1:0] res_s1;
	logic [hbb_pkg::SLOTS-1:0]  low_bit;
	logic [hbb_pkg::SLOTS-1:0]  rest;
	logic [1:0]                 sel;
	logic                       move;
	logic                       out_valid_q;
	hbb_pkg::pixel_t            out_px_q;
	logic                       row_end_q;
	logic                       last_q;

	assign low_bit = pend_s1 & (~pend_s1 + hbb_pkg::SLOTS'(1));
	assign rest    = pend_s1 & ~low_bit;
	assign move    = (|pend_s1) && (!out_valid_q || pix_out.ready);
	assign free    = (pend_s1 == '0) || (move && (rest == '0));

	always_comb begin
		if (pend_s1[0]) begin
			sel = 2'd0;
		end else if (pend_s1[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= '0;
		end else if (load) begin
			pend_s1 <= run.mask;
		end else if (move) begin
			pend_s1 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s1 <= run.px;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_px_q  <= res_s1[sel];
			row_end_q <= (sel == 2'd2);
			last_q    <= (rest == '0);
		end
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.red_out     = out_px_q.red;
	assign pix_out.green_out   = out_px_q.green;
	assign pix_out.blue_out    = out_px_q.blue;
	assign pix_out.row_end     = row_end_q;
	assign pix_out.last_of_run = last_q;

endmodule

FILE: rtl/core/hbb_checker.sv
// port-level checks for the horizontal binomial blur
`include "horizontal_binomial_blur_assert.svh"

module hbb_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [hbb_pkg::CHAN_W-1:0] red_out,
	input logic [hbb_pkg::CHAN_W-1:0] green_out,
	input logic [hbb_pkg::CHAN_W-1:0] blue_out,
	input logic                       row_end,
	input logic                       last_of_run
);

	// the rest of a run follows without a gap
	`HBB_ASSERT_NEXT(a_run_contiguous, clk, arst_n, out_valid && out_ready && !last_of_run, out_valid)

	// the row-end word always closes its run
	`HBB_ASSERT_NOW(a_row_end_closes, clk, arst_n, out_valid && row_end, last_of_run)

	// a stalled word holds
	`HBB_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(row_end) && $stable(last_of_run))

endmodule

bind horizontal_binomial_blur hbb_checker u_hbb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (pix_out.valid),
	.out_ready   (pix_out.ready),
	.red_out     (pix_out.red_out),
	.green_out   (pix_out.green_out),
	.blue_out    (pix_out.blue_out),
	.row_end     (pix_out.row_end),
	.last_of_run (pix_out.last_of_run)
);

FILE: tb/sv/horizontal_binomial_blur_checker.sv
// checker for the horizontal binomial blur: predicts blurred words and compares them
`timescale 1ns / 100ps

module horizontal_binomial_blur_checker
	import hbb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [ROW_W-1:0] cfg_wr_data,
	hbb_in_if                in_mon,
	hbb_out_if               out_mon,
	output int               fail_count,
	output int               pending_count
);

	localparam int unsigned BLUR_TAPS [TAPS] = '{1, 4, 6, 4, 1};
	localparam int MAX_PRINTED = 40;

	typedef struct {
		pixel_t px;
		logic   row_end;
		logic   last_of_run;
	} blurred_word_t;

	blurred_word_t    blurred_q[$];
	blurred_word_t    oldest;
	logic [ROW_W-1:0] width_reg;
	pixel_t           history [4];
	pixel_t           window [7];
	int unsigned      column;

	initial begin
		fail_count    = 0;
		pending_count = 0;
		width_reg     = ROW_WIDTH_RST;
		column        = 0;
		for (int i = 0; i < 4; i++) history[i] = '0;
	end

	task automatic report_mismatch(input string what);
		if (fail_count < MAX_PRINTED)
			$display("mismatch at %0t ns: %s", $time, what);
		fail_count++;
	endtask

	function automatic pixel_t blur_at(input int start);
		int unsigned sr, sg, sb;
		pixel_t px;
		sr = 0;
		sg = 0;
		sb = 0;
		for (int k = 0; k < TAPS; k++) begin
			sr += BLUR_TAPS[k] * window[start + k].red;
			sg += BLUR_TAPS[k] * window[start + k].green;
			sb += BLUR_TAPS[k] * window[start + k].blue;
		end
		px.red   = CHAN_W'(sr >> 4);
		px.green = CHAN_W'(sg >> 4);
		px.blue  = CHAN_W'(sb >> 4);
		return px;
	endfunction

	task automatic store_word(input pixel_t px, input logic row_end, input logic final_one);
		blurred_word_t w;
		w.px          = px;
		w.row_end     = row_end;
		w.last_of_run = final_one;
		blurred_q.push_back(w);
	endtask

	task automatic predict_blur(input pixel_t cur);
		int unsigned w, c;
		bit last;
		int n, k;
		w = width_reg;
		if (w == 0) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		c = column;
		last = (c >= w - 1);
		if (c == 0)
			for (int i = 0; i < 4; i++) history[i] = cur;
		window[0] = history[3];
		window[1] = history[2];
		window[2] = history[1];
		window[3] = history[0];
		window[4] = cur;
		window[5] = cur;
		window[6] = cur;
		n = 0;
		if (c >= 2) n++;
		if (last) begin
			if (c >= 1) n++;
			n++;
		end
		k = 0;
		if (c >= 2) begin
			store_word(blur_at(0), 1'b0, k == n - 1);
			k++;
		end
		if (last) begin
			if (c >= 1) begin
				store_word(blur_at(1), 1'b0, k == n - 1);
				k++;
			end
			store_word(blur_at(2), 1'b1, k == n - 1);
		end
		history[3] = history[2];
		history[2] = history[1];
		history[1] = history[0];
		history[0] = cur;
		column = last ? 0 : ((c + 1) & 32'hFFFFF);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			width_reg = ROW_WIDTH_RST;
			column    = 0;
			for (int i = 0; i < 4; i++) history[i] = '0;
			blurred_q.delete();
		end else begin
			if (cfg_wr_en)
				width_reg = cfg_wr_data;
			if (in_mon.valid && in_mon.ready)
				predict_blur({in_mon.red_in, in_mon.green_in, in_mon.blue_in});
			if (out_mon.valid && out_mon.ready) begin
				if (blurred_q.size() == 0) begin
					report_mismatch("output word with nothing expected");
				end else begin
					oldest = blurred_q.pop_front();
					if (out_mon.red_out !== oldest.px.red)
						report_mismatch($sformatf("red_out %0d, expected %0d",
							out_mon.red_out, oldest.px.red));
					if (out_mon.green_out !== oldest.px.green)
						report_mismatch($sformatf("green_out %0d, expected %0d",
							out_mon.green_out, oldest.px.green));
					if (out_mon.blue_out !== oldest.px.blue)
						report_mismatch($sformatf("blue_out %0d, expected %0d",
							out_mon.blue_out, oldest.px.blue));
					if (out_mon.row_end !== oldest.row_end)
						report_mismatch($sformatf("row_end %b, expected %b",
							out_mon.row_end, oldest.row_end));
					if (out_mon.last_of_run !== oldest.last_of_run)
						report_mismatch($sformatf("last_of_run %b, expected %b",
							out_mon.last_of_run, oldest.last_of_run));
				end
			end
		end
		pending_count <= blurred_q.size();
	end

endmodule

FILE: tb/sv/horizontal_binomial_blur_tb.sv
// testbench top for the horizontal binomial blur: stimulus, flow control and verdict
`timescale 1ns / 100ps

module horizontal_binomial_blur_tb;
	import hbb_pkg::*;

	localparam int RANDOM_ITEMS = 135;
	localparam int QUIET_AFTER  = 110;
	localparam int HOLD_CYCLES  = 40;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [ROW_W-1:0] cfg_wr_data;
	int               fail_total;
	int               pending_words;
	bit               hold_request;
	bit               quiet;
	bit               sender_calm;

	hbb_in_if  in_ch ();
	hbb_out_if out_ch ();

	horizontal_binomial_blur DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.pix_in     (in_ch),
		.pix_out    (out_ch)
	);

	horizontal_binomial_blur_checker blur_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_mon       (in_ch),
		.out_mon      (out_ch),
		.fail_count   (fail_total),
		.pending_count(pending_words)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// output side flow control
	initial begin
		out_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	function automatic logic [CHAN_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CHAN_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		return {pick_level(), pick_level(), pick_level()};
	endfunction

	function automatic logic [ROW_W-1:0] pick_row_width();
		case ($urandom_range(0, 9))
			0: return ROW_W'(1);
			1: return ROW_W'(2);
			2: return ROW_W'(3);
			7: return ROW_W'(0);
			8: return ROW_W'($urandom_range(13, 40));
			9: return ($urandom_range(0, 1) == 0) ? ROW_W'(MAX_WIDTH)
				: ROW_W'($urandom_range(MAX_WIDTH + 1, 8191));
			default: return ROW_W'($urandom_range(4, 12));
		endcase
	endfunction

	task automatic write_row_width(input logic [ROW_W-1:0] w);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic send_pixel(input pixel_t px);
		if (!quiet && !sender_calm && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.red_in   <= px.red;
		in_ch.green_in <= px.green;
		in_ch.blue_in  <= px.blue;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int random_sent;
		int count;
		bit first;
		logic [ROW_W-1:0] w;

		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		in_ch.valid    = 1'b0;
		in_ch.red_in   = '0;
		in_ch.green_in = '0;
		in_ch.blue_in  = '0;
		hold_request   = 1'b0;
		quiet          = 1'b0;
		sender_calm    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset width, extremes of every channel
		send_pixel({8'd0, 8'd0, 8'd0});
		send_pixel({8'd255, 8'd255, 8'd255});
		send_pixel({8'd255, 8'd0, 8'd0});
		send_pixel({8'd0, 8'd255, 8'd0});
		send_pixel({8'd0, 8'd0, 8'd255});
		send_pixel({8'd255, 8'd255, 8'd255});
		send_pixel({8'd0, 8'd0, 8'd0});
		send_pixel({8'd170, 8'd85, 8'd170});
		send_pixel({8'd85, 8'd170, 8'd85});
		settle();

		// width shrunk below the current column
		write_row_width(ROW_W'(4));
		send_pixel({8'd255, 8'd255, 8'd255});
		repeat (4) send_pixel(random_pixel());
		settle();

		write_row_width(ROW_W'(1));
		repeat (2) send_pixel(random_pixel());
		settle();

		write_row_width(ROW_W'(2));
		repeat (3) send_pixel(random_pixel());
		settle();

		// zero width acts as one
		write_row_width(ROW_W'(0));
		repeat (2) send_pixel(random_pixel());
		settle();

		// oversized width acts as the maximum, then shrink mid row
		write_row_width(ROW_W'(8191));
		repeat (3) send_pixel(random_pixel());
		settle();
		write_row_width(ROW_W'(3));
		send_pixel({8'd0, 8'd0, 8'd0});
		settle();

		random_sent = 0;
		first = 1'b1;
		while (random_sent < RANDOM_ITEMS) begin
			if (first) begin
				w = ROW_W'(3);
				count = 24;
			end else begin
				w = pick_row_width();
				if (w > 40)
					count = $urandom_range(1, 6);
				else if (w == 0)
					count = $urandom_range(1, 4);
				else
					count = $urandom_range(1, (3 * w + 2 > 24) ? 24 : 3 * w + 2);
			end
			write_row_width(w);
			sender_calm = first || ($urandom_range(0, 2) == 0);
			if (first)
				hold_request = 1'b1;
			repeat (count) begin
				send_pixel(random_pixel());
				random_sent++;
				if (random_sent >= QUIET_AFTER)
					quiet = 1'b1;
			end
			settle();
			first = 1'b0;
		end

		repeat (8) @(posedge clk);
		if (fail_total == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: horizontal_binomial_blur.f
+incdir+rtl/core
rtl/core/hbb_pkg.sv
rtl/core/hbb_in_if.sv
rtl/core/hbb_out_if.sv
rtl/core/hbb_lane.sv
rtl/core/hbb_merge.sv
rtl/core/horizontal_binomial_blur.sv
rtl/core/hbb_checker.sv
tb/sv/horizontal_binomial_blur_checker.sv
tb/sv/horizontal_binomial_blur_tb.sv
